@@ rtl/lgs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types for the life grid generation step core.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int ROWS  = 32;
    localparam int COLS  = 64;

    // Item field widths
    localparam int OP_W  = 2;
    localparam int ROW_W = 5;
    localparam int COL_W = 6;

    // Sweep counter width, one count per row cell
    localparam int CNT_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef logic [COLS-1:0] t_row;

endpackage
`default_nettype wire

@@ rtl/lgs_row_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_row_cell
// One row of the grid. Takes the row of its neighbor on every shift cycle.
// ----------------------------------------------------------------------------
module lgs_row_cell
    import lgs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_shift,
    input  wire t_row i_row_in,
    output t_row      o_row
);

    t_row r_row;
    t_row n_row;

    always_comb begin
        n_row = r_row;
        if (i_shift) begin
            n_row = i_row_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule
`default_nettype wire

@@ rtl/lgs_row_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_row_update
// B3/S23 update of one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module lgs_row_update
    import lgs_pkg::*;
(
    input  wire t_row i_prev,
    input  wire t_row i_cur,
    input  wire t_row i_next,
    output t_row      o_new
);

    // rows padded by one dead cell on each side
    logic [COLS+1:0] w_p;
    logic [COLS+1:0] w_c;
    logic [COLS+1:0] w_n;

    assign w_p = {1'b0, i_prev, 1'b0};
    assign w_c = {1'b0, i_cur,  1'b0};
    assign w_n = {1'b0, i_next, 1'b0};

    always_comb begin
        logic [3:0] cnt;
        o_new = '0;
        for (int c = 0; c < COLS; c++) begin
            cnt = {3'b0, w_p[c]} + {3'b0, w_p[c+1]} + {3'b0, w_p[c+2]}
                + {3'b0, w_c[c]} + {3'b0, w_c[c+2]}
                + {3'b0, w_n[c]} + {3'b0, w_n[c+1]} + {3'b0, w_n[c+2]};
            o_new[c] = (cnt == 4'd3) || (i_cur[c] && (cnt == 4'd2));
        end
    end

endmodule
`default_nettype wire

@@ rtl/life_grid_generation_step_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_generation_step_core
// Game of Life grid (B3/S23) with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries op, row, col, alive.
//   Output channel o_out_valid / i_out_stall carries cell_value; one beat
//   out for every beat in, in order.
//   The grid sits in a ring of ROWS row cells. Every item rotates the ring
//   once; the head of the ring is where a row is read, written or updated
//   from its two neighbors on its way back to the tail.
//   The core takes no new item until the output beat of the last one has
//   been handed to the output register.
//   Reset clears every cell to dead and empties the output register.
//   While the receiver stalls, the output beat holds; a finished item then
//   waits in the core and no new input beat is taken.
// ----------------------------------------------------------------------------
module life_grid_generation_step_core
    import lgs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire  [OP_W-1:0]  i_op,
    input  wire  [ROW_W-1:0] i_row,
    input  wire  [COL_W-1:0] i_col,
    input  wire              i_alive,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic             o_cell_value
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_t, n_t;
    logic [OP_W-1:0]  r_op;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_alive;
    t_row             r_prev, n_prev;
    logic             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic             r_out_value, n_out_value;

    t_row w_rows [ROWS];
    t_row w_tail;
    t_row w_next;
    t_row w_new;
    t_row w_written;
    logic w_shift;
    logic w_accept;
    logic w_last;
    logic w_hit_row;
    logic w_col_bit;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_shift  = (r_state == ST_SWEEP);
    assign w_last   = (r_t == CNT_W'(ROWS - 1));
    assign w_hit_row = (32'(r_t) == 32'(r_row));

    // ring of row cells, head at index 0, tail fed from the head logic
    for (genvar k = 0; k < ROWS; k++) begin : g_cell
        t_row w_in;
        if (k == ROWS - 1) begin : g_tail
            assign w_in = w_tail;
        end else begin : g_link
            assign w_in = w_rows[k+1];
        end
        lgs_row_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_row_in (w_in),
            .o_row    (w_rows[k])
        );
    end

    // on the last row, cell 1 already holds the new first row
    assign w_next = w_last ? '0 : w_rows[1];

    lgs_row_update u_update (
        .i_prev (r_prev),
        .i_cur  (w_rows[0]),
        .i_next (w_next),
        .o_new  (w_new)
    );

    always_comb begin
        w_written = w_rows[0];
        w_col_bit = 1'b0;
        for (int c = 0; c < COLS; c++) begin
            if (32'(c) == 32'(r_col)) begin
                w_written[c] = r_alive;
                w_col_bit    = w_rows[0][c];
            end
        end
    end

    always_comb begin
        w_tail = w_rows[0];
        case (r_op)
            OP_STEP:  w_tail = w_new;
            OP_WRITE: if (w_hit_row) begin
                w_tail = w_written;
            end
            default:  w_tail = w_rows[0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_prev      = r_prev;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWEEP;
                    n_t     = '0;
                    n_prev  = '0;
                    n_res   = 1'b0;
                end
            end
            ST_SWEEP: begin
                n_prev = w_rows[0];
                n_t    = r_t + 1'b1;
                if ((r_op == OP_READ) && w_hit_row) begin
                    n_res = w_col_bit;
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_t         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_t         <= n_t;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_res       <= n_res;
        r_out_value <= n_out_value;
        if (w_accept) begin
            r_op    <= i_op;
            r_row   <= i_row;
            r_col   <= i_col;
            r_alive <= i_alive;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;

endmodule
`default_nettype wire
